@@ src/spq_pkg.sv @@
// Shared constants and types for the sorted priority queue.
package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int PRIO_W      = 16;
    localparam int DATA_W      = 32;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 5;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic signed [PRIO_W-1:0] prio;
        logic        [DATA_W-1:0] data;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_INS  = 3'b010,
        S_REM  = 3'b100
    } state_t;

endpackage

@@ src/sorted_priority_queue.sv @@
// Sorted priority queue: entry store in one synchronous RAM, head cached in registers.
//
// Usage: drive operation, priority_req and payload with start high; the
// transaction is taken at a clock edge where start is high and busy is low.
// Insert (operation 0) places the entry ahead of all entries of lower or
// equal priority; remove (operation 1) takes out the highest entry.
// Every transaction gives exactly one result, shown for one cycle with done
// high: status, the removed entry (zero unless a remove succeeded), the head
// after the transaction (zero if empty), head_valid and entry_count.
// Flow: refused transactions, an insert into an empty queue and a remove
// leaving the queue empty give done in the cycle after acceptance, with busy
// never raised. Otherwise the RAM is walked one entry per cycle with a
// read-compare-write loop: an insert walks down from the tail, shifting entries
// of lower or equal priority up; a remove shifts each entry behind the head down.
// A new transaction may be accepted in the cycle its predecessor's done shows.
// The receiver cannot stall: done is a strobe and must be taken when shown.
// Reset empties the queue at once; RAM contents are not cleared, as only
// positions below the count are ever used.
module sorted_priority_queue (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic                                  operation,
    input  logic signed [spq_pkg::PRIO_W-1:0]     priority_req,
    input  logic        [spq_pkg::DATA_W-1:0]     payload,
    output logic                                  busy,
    output logic                                  done,
    output logic        [spq_pkg::STATUS_W-1:0]   status,
    output logic signed [spq_pkg::PRIO_W-1:0]     removed_priority,
    output logic        [spq_pkg::DATA_W-1:0]     removed_payload,
    output logic                                  head_valid,
    output logic signed [spq_pkg::PRIO_W-1:0]     head_priority,
    output logic        [spq_pkg::DATA_W-1:0]     head_payload,
    output logic        [spq_pkg::COUNT_OUT_W-1:0] entry_count
);
    import spq_pkg::*;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [ADDR_W-1:0]     idx_reg, idx_next;
    entry_t                head_reg, head_next;
    entry_t                new_reg, new_next;
    entry_t                rem_reg, rem_next;

    entry_t                mem [QUEUE_DEPTH];
    entry_t                rdata_reg;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_wa;
    logic [ADDR_W-1:0]     mem_ra;
    entry_t                mem_wd;

    logic                  finish;
    logic [STATUS_W-1:0]   status_v;

    logic                  done_reg;
    logic [STATUS_W-1:0]   status_reg;
    entry_t                removed_reg;
    logic                  head_valid_reg;
    entry_t                head_out_reg;
    logic [CNT_W-1:0]      count_out_reg;

    entry_t                req_entry;

    assign req_entry = '{prio: priority_req, data: payload};
    assign busy      = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        head_next  = head_reg;
        new_next   = new_reg;
        rem_next   = rem_reg;
        mem_we     = 1'b0;
        mem_wa     = idx_reg;
        mem_wd     = new_reg;
        mem_ra     = idx_reg;
        finish     = 1'b0;
        status_v   = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (operation == OP_INSERT)
                    begin
                        rem_next = '0;
                        new_next = req_entry;
                        if (count_reg == CNT_W'(QUEUE_DEPTH))
                        begin
                            status_v = ST_FULL;
                            finish   = 1'b1;
                        end
                        else if (count_reg == '0)
                        begin
                            mem_we     = 1'b1;
                            mem_wa     = '0;
                            mem_wd     = req_entry;
                            head_next  = req_entry;
                            count_next = CNT_W'(1);
                            finish     = 1'b1;
                        end
                        else
                        begin
                            // walk down from the tail, shifting lower or equal entries up
                            idx_next   = ADDR_W'(count_reg);
                            mem_ra     = ADDR_W'(count_reg - CNT_W'(1));
                            state_next = S_INS;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            rem_next = '0;
                            status_v = ST_EMPTY;
                            finish   = 1'b1;
                        end
                        else
                        begin
                            rem_next = head_reg;
                            if (count_reg == CNT_W'(1))
                            begin
                                count_next = '0;
                                finish     = 1'b1;
                            end
                            else
                            begin
                                idx_next   = ADDR_W'(1);
                                mem_ra     = ADDR_W'(1);
                                state_next = S_REM;
                            end
                        end
                    end
                end
            end
            S_INS:
            begin
                mem_we = 1'b1;
                mem_wa = idx_reg;
                if (idx_reg == '0)
                begin
                    mem_wd     = new_reg;
                    head_next  = new_reg;
                    count_next = count_reg + CNT_W'(1);
                    finish     = 1'b1;
                    state_next = S_IDLE;
                end
                else if (rdata_reg.prio > new_reg.prio)
                begin
                    mem_wd     = new_reg;
                    count_next = count_reg + CNT_W'(1);
                    finish     = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    // reads idx-2 while writing idx: never the same entry
                    mem_wd   = rdata_reg;
                    idx_next = idx_reg - ADDR_W'(1);
                    mem_ra   = idx_reg - ADDR_W'(2);
                end
            end
            S_REM:
            begin
                mem_we = 1'b1;
                mem_wa = idx_reg - ADDR_W'(1);
                mem_wd = rdata_reg;
                if (idx_reg == ADDR_W'(1))
                begin
                    head_next = rdata_reg;
                end
                if (CNT_W'(idx_reg) + CNT_W'(1) == count_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                    finish     = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + ADDR_W'(1);
                    mem_ra   = idx_reg + ADDR_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rdata_reg <= mem[mem_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= finish;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        head_reg <= head_next;
        new_reg  <= new_next;
        rem_reg  <= rem_next;
        if (finish)
        begin
            status_reg     <= status_v;
            removed_reg    <= rem_next;
            head_valid_reg <= (count_next != '0);
            head_out_reg   <= (count_next != '0) ? head_next : '0;
            count_out_reg  <= count_next;
        end
    end

    assign done             = done_reg;
    assign status           = status_reg;
    assign removed_priority = removed_reg.prio;
    assign removed_payload  = removed_reg.data;
    assign head_valid       = head_valid_reg;
    assign head_priority    = head_out_reg.prio;
    assign head_payload     = head_out_reg.data;
    assign entry_count      = COUNT_OUT_W'(count_out_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above depth");

    a_busy_ends_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("walk ended without a result");

    a_head_valid_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (head_valid == (entry_count != '0)))
        else $error("head_valid disagrees with entry_count");

    a_rem_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REM) |-> (CNT_W'(idx_reg) < count_reg))
        else $error("remove walk beyond the last entry");

    a_write_below_count: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (CNT_W'(mem_wa) <= count_reg))
        else $error("RAM write beyond the occupied range");

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the sorted priority queue: random insert/remove traffic.
`timescale 1ns / 1ps

module tb;
    import spq_pkg::*;

    typedef struct packed {
        logic                     op;
        logic signed [PRIO_W-1:0] prio;
        logic        [DATA_W-1:0] data;
    } queue_op_t;

    typedef struct packed {
        logic        [STATUS_W-1:0]    status;
        logic signed [PRIO_W-1:0]      rem_prio;
        logic        [DATA_W-1:0]      rem_data;
        logic                          head_ok;
        logic signed [PRIO_W-1:0]      head_prio;
        logic        [DATA_W-1:0]      head_data;
        logic        [COUNT_OUT_W-1:0] count;
    } outcome_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic operation = OP_INSERT;
    logic signed [PRIO_W-1:0] priority_req = '0;
    logic [DATA_W-1:0] payload = '0;
    logic busy;
    logic done;
    logic [STATUS_W-1:0] status;
    logic signed [PRIO_W-1:0] removed_priority;
    logic [DATA_W-1:0] removed_payload;
    logic head_valid;
    logic signed [PRIO_W-1:0] head_priority;
    logic [DATA_W-1:0] head_payload;
    logic [COUNT_OUT_W-1:0] entry_count;

    sorted_priority_queue u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .operation        (operation),
        .priority_req     (priority_req),
        .payload          (payload),
        .busy             (busy),
        .done             (done),
        .status           (status),
        .removed_priority (removed_priority),
        .removed_payload  (removed_payload),
        .head_valid       (head_valid),
        .head_priority    (head_priority),
        .head_payload     (head_payload),
        .entry_count      (entry_count)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Shadow of the sorted store, index 0 is the head
    logic signed [PRIO_W-1:0] held_prio [QUEUE_DEPTH];
    logic        [DATA_W-1:0] held_data [QUEUE_DEPTH];
    int unsigned              held_count = 0;

    queue_op_t   pending_ops[$];
    outcome_t    expected_outcomes[$];
    int unsigned error_count = 0;
    int unsigned gap_left = 0;
    int unsigned burst_left = 0;
    logic        took = 1'b0;

    function automatic outcome_t apply_queue_op(queue_op_t r);
        outcome_t    o;
        int unsigned pos;
        int unsigned i;
        o = '0;
        if (r.op == OP_INSERT) begin
            if (held_count >= QUEUE_DEPTH) begin
                o.status = ST_FULL;
            end else begin
                pos = 0;
                while (pos < held_count && held_prio[pos] > r.prio)
                    pos++;
                for (i = held_count; i > pos; i--) begin
                    held_prio[i] = held_prio[i-1];
                    held_data[i] = held_data[i-1];
                end
                held_prio[pos] = r.prio;
                held_data[pos] = r.data;
                held_count++;
            end
        end else begin
            if (held_count == 0) begin
                o.status = ST_EMPTY;
            end else begin
                o.rem_prio = held_prio[0];
                o.rem_data = held_data[0];
                for (i = 1; i < held_count; i++) begin
                    held_prio[i-1] = held_prio[i];
                    held_data[i-1] = held_data[i];
                end
                held_count--;
            end
        end
        if (held_count > 0) begin
            o.head_ok   = 1'b1;
            o.head_prio = held_prio[0];
            o.head_data = held_data[0];
        end
        o.count = held_count[COUNT_OUT_W-1:0];
        return o;
    endfunction

    task automatic flag_error(string what);
        error_count++;
        if (error_count <= 10)
            $display("%0t ERROR: %s", $realtime, what);
    endtask

    function automatic string show(outcome_t o);
        return $sformatf("st=%0d rem=%0d/%h head=%0d:%0d/%h n=%0d", o.status, o.rem_prio,
                         o.rem_data, o.head_ok, o.head_prio, o.head_data, o.count);
    endfunction

    // Mostly back to back or short gaps, a few long ones, plus gap-free bursts
    function automatic int unsigned next_gap();
        int unsigned r;
        if (burst_left != 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(99);
        if (r < 8) begin
            burst_left = $urandom_range(60, 20);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(15, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic logic signed [PRIO_W-1:0] pick_prio();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 40)
            return PRIO_W'($signed($urandom_range(8)) - 4);
        if (r < 55) begin
            case ($urandom_range(3))
                0: return 16'sh8000;
                1: return 16'sh8001;
                2: return 16'sh7ffe;
                default: return 16'sh7fff;
            endcase
        end
        return PRIO_W'($urandom);
    endfunction

    task automatic add_op(logic op, logic signed [PRIO_W-1:0] prio, logic [DATA_W-1:0] data);
        queue_op_t q;
        q.op   = op;
        q.prio = prio;
        q.data = data;
        pending_ops.push_back(q);
    endtask

    // Driver: transaction held until start && !busy seen at a rising edge
    always @(negedge clk)
    begin
        queue_op_t nxt;
        if (!rst_n) begin
            start <= 1'b0;
        end else if (start && !took) begin
            // still waiting for acceptance
        end else if (gap_left != 0) begin
            start    <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (pending_ops.size() != 0) begin
            nxt = pending_ops.pop_front();
            start        <= 1'b1;
            operation    <= nxt.op;
            priority_req <= nxt.prio;
            payload      <= nxt.data;
            gap_left     <= next_gap();
        end else begin
            start <= 1'b0;
        end
    end

    // Acceptance: predict the outcome of each transaction taken
    always @(posedge clk)
    begin
        queue_op_t cur;
        if (!rst_n) begin
            took <= 1'b0;
        end else begin
            took <= start && !busy;
            if (start && !busy) begin
                cur.op   = operation;
                cur.prio = priority_req;
                cur.data = payload;
                expected_outcomes.push_back(apply_queue_op(cur));
            end
        end
    end

    // Monitor: done is a one-cycle strobe
    always @(posedge clk)
    begin
        outcome_t got;
        outcome_t want;
        if (rst_n && done) begin
            got = '{status, removed_priority, removed_payload, head_valid,
                    head_priority, head_payload, entry_count};
            if (expected_outcomes.size() == 0) begin
                flag_error({"result with no transaction outstanding: ", show(got)});
            end else begin
                want = expected_outcomes.pop_front();
                if (got.status !== want.status || got.rem_prio !== want.rem_prio ||
                    got.rem_data !== want.rem_data || got.head_ok !== want.head_ok ||
                    got.head_prio !== want.head_prio || got.head_data !== want.head_data ||
                    got.count !== want.count)
                    flag_error({"mismatch exp ", show(want), " got ", show(got)});
            end
        end
    end

    initial
    begin
        int unsigned seg_len;
        int unsigned mode;
        int unsigned ins_pct;
        int unsigned made;

        // Directed: remove from empty, fill with extremes and ties, overflow, drain a few
        add_op(OP_REMOVE, 16'sd0, 32'h0);
        add_op(OP_INSERT, 16'sh8000, 32'h0000_0000);
        add_op(OP_INSERT, 16'sh7fff, 32'hffff_ffff);
        add_op(OP_INSERT, 16'sd5, 32'h5555_000a);
        add_op(OP_INSERT, 16'sd5, 32'h5555_000b);
        add_op(OP_INSERT, 16'sd5, 32'h5555_000c);
        add_op(OP_INSERT, 16'sd7, 32'h7777_7777);
        add_op(OP_INSERT, 16'sd0, 32'haaaa_aaaa);
        add_op(OP_INSERT, -16'sd1, 32'h5555_5555);
        add_op(OP_INSERT, 16'sh7fff, 32'h8000_0001);
        add_op(OP_INSERT, 16'sh8000, 32'h0000_0001);
        add_op(OP_INSERT, 16'sd6, 32'h6666_6666);
        add_op(OP_INSERT, 16'sd100, 32'h1234_5678);
        add_op(OP_INSERT, -16'sd100, 32'h8765_4321);
        add_op(OP_INSERT, 16'sd1, 32'h0f0f_0f0f);
        add_op(OP_INSERT, 16'sd2, 32'hf0f0_f0f0);
        add_op(OP_INSERT, 16'sd3, 32'hdead_beef);
        add_op(OP_INSERT, 16'sd4, 32'hcafe_f00d);
        add_op(OP_REMOVE, 16'sd0, 32'h0);
        add_op(OP_REMOVE, 16'sd0, 32'h0);
        add_op(OP_REMOVE, 16'sd0, 32'h0);
        add_op(OP_REMOVE, 16'sd0, 32'h0);

        // Random: segments biased towards filling, draining or balanced traffic
        made = pending_ops.size();
        while (made < 1450) begin
            seg_len = $urandom_range(60, 10);
            mode    = $urandom_range(2);
            ins_pct = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
            repeat (seg_len) begin
                if ($urandom_range(99) < ins_pct)
                    add_op(OP_INSERT, pick_prio(), $urandom);
                else
                    add_op(OP_REMOVE, PRIO_W'($urandom), $urandom);
                made++;
            end
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_ops.size() != 0 || start)
            @(posedge clk);
        while (expected_outcomes.size() != 0)
            @(posedge clk);
        // insert shifting every entry of a store one short of full is the slowest case
        repeat (QUEUE_DEPTH + 8) @(posedge clk);

        if (expected_outcomes.size() != 0)
            flag_error("results still outstanding at end of run");
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout with %0d results outstanding", expected_outcomes.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ sorted_priority_queue.f @@
src/spq_pkg.sv
src/sorted_priority_queue.sv
tb/tb.sv
